[rtl/utf8_single_line_text_checker_assert.svh]
// assertion macros shared by the checker rtl
`ifndef UTF8_SINGLE_LINE_TEXT_CHECKER_ASSERT_SVH
`define UTF8_SINGLE_LINE_TEXT_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define U8C_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define U8C_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/u8c_pkg.sv]
package u8c_pkg;

	// allowed range of the next continuation byte
	typedef enum logic [2:0] {
		CLS_NORM = 3'd0,	// 0x80..0xbf
		CLS_A0BF = 3'd1,	// after 0xe0
		CLS_809F = 3'd2,	// after 0xed
		CLS_90BF = 3'd3,	// after 0xf0
		CLS_808F = 3'd4		// after 0xf4
	} cls_t;

	localparam int unsigned CP_W = 21;

	// per-string decoder state
	typedef struct packed {
		logic            err;
		logic [CP_W-1:0] cp;
		cls_t            cls;
		logic [1:0]      pending;
	} dec_state_t;

endpackage

[rtl/u8c_step.sv]
module u8c_step (
	input  logic                  token_mode,
	input  logic [7:0]            text_byte,
	input  u8c_pkg::dec_state_t   st,
	output u8c_pkg::dec_state_t   nxt
);

	localparam logic [7:0] LEAD2_MIN = 8'hc2;
	localparam logic [7:0] LEAD2_MAX = 8'hdf;
	localparam logic [7:0] LEAD3_E0  = 8'he0;
	localparam logic [7:0] LEAD3_ED  = 8'hed;
	localparam logic [7:0] LEAD4_F0  = 8'hf0;
	localparam logic [7:0] LEAD4_F4  = 8'hf4;
	localparam logic [7:0] CONT_A0   = 8'ha0;
	localparam logic [7:0] CONT_9F   = 8'h9f;
	localparam logic [7:0] CONT_90   = 8'h90;
	localparam logic [7:0] CONT_8F   = 8'h8f;
	localparam logic [7:0] CONT_BF   = 8'hbf;
	localparam logic [7:0] CONT_80   = 8'h80;

	// code point allowed on a single line
	function automatic logic line_safe(input logic [u8c_pkg::CP_W-1:0] cp);
		logic ok;
		ok = 1'b1;
		if (cp <= 21'h1f) ok = 1'b0;
		if (cp >= 21'h7f && cp <= 21'h9f) ok = 1'b0;
		if (cp == 21'h2028 || cp == 21'h2029) ok = 1'b0;
		return ok;
	endfunction

	// ascii whitespace: space, tab, lf, vt, ff, cr
	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
	endfunction

	logic                     cls_hit;
	logic [u8c_pkg::CP_W-1:0] cp_cont;

	// continuation byte range check
	always_comb begin
		unique case (st.cls)
			u8c_pkg::CLS_A0BF: cls_hit = (text_byte >= CONT_A0) && (text_byte <= CONT_BF);
			u8c_pkg::CLS_809F: cls_hit = (text_byte >= CONT_80) && (text_byte <= CONT_9F);
			u8c_pkg::CLS_90BF: cls_hit = (text_byte >= CONT_90) && (text_byte <= CONT_BF);
			u8c_pkg::CLS_808F: cls_hit = (text_byte >= CONT_80) && (text_byte <= CONT_8F);
			default:           cls_hit = (text_byte >= CONT_80) && (text_byte <= CONT_BF);
		endcase
	end

	assign cp_cont = {st.cp[u8c_pkg::CP_W-7:0], text_byte[5:0]};

	// one byte of the utf-8 decode
	always_comb begin
		nxt = st;
		if (!st.err) begin
			if (st.pending == 2'd0) begin
				if (!text_byte[7]) begin
					if (!line_safe({13'd0, text_byte}) || (token_mode && is_space(text_byte)))
						nxt.err = 1'b1;
				end else if (text_byte >= LEAD2_MIN && text_byte <= LEAD2_MAX) begin
					nxt.pending = 2'd1;
					nxt.cls     = u8c_pkg::CLS_NORM;
					nxt.cp      = {16'd0, text_byte[4:0]};
				end else if (text_byte[7:4] == 4'he) begin
					nxt.pending = 2'd2;
					if (text_byte == LEAD3_E0)      nxt.cls = u8c_pkg::CLS_A0BF;
					else if (text_byte == LEAD3_ED) nxt.cls = u8c_pkg::CLS_809F;
					else                            nxt.cls = u8c_pkg::CLS_NORM;
					nxt.cp      = {17'd0, text_byte[3:0]};
				end else if (text_byte >= LEAD4_F0 && text_byte <= LEAD4_F4) begin
					nxt.pending = 2'd3;
					if (text_byte == LEAD4_F0)      nxt.cls = u8c_pkg::CLS_90BF;
					else if (text_byte == LEAD4_F4) nxt.cls = u8c_pkg::CLS_808F;
					else                            nxt.cls = u8c_pkg::CLS_NORM;
					nxt.cp      = {18'd0, text_byte[2:0]};
				end else begin
					nxt.err = 1'b1;
				end
			end else if (!cls_hit) begin
				nxt.err = 1'b1;
			end else begin
				nxt.cls     = u8c_pkg::CLS_NORM;
				nxt.cp      = cp_cont;
				nxt.pending = st.pending - 2'd1;
				if (st.pending == 2'd1 && !line_safe(cp_cont))
					nxt.err = 1'b1;
			end
		end
	end

endmodule

[rtl/utf8_single_line_text_checker.sv]
// path: an accepted byte is held in the input register; its string's result then goes to the result register
// throughput: one byte per cycle unless a string's result finds the output full, set by the
//   single-pass decode between the input register and the result register
// reset: arst_n clears the pipeline valids, the decoder state and token_mode
module utf8_single_line_text_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,	// token_mode
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,	// [7:0] text_byte
	input  logic       s_axis_tlast,	// end_of_text
	input  logic       s_axis_tuser,	// [0] empty_text
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata	// [0] text_ok, [7:1] zero
);

`include "utf8_single_line_text_checker_assert.svh"

	logic                token_mode_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                empty_s1;
	u8c_pkg::dec_state_t st_q;
	u8c_pkg::dec_state_t st_nxt;
	logic                valid_s2;
	logic                text_ok_s2;
	logic                has_result_s1;
	logic                adv_s1;
	logic                text_ok_s1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			token_mode_q <= cfg_wr_data;
		end
	end

	// handshake: stage 1 moves unless its result finds the output full
	assign has_result_s1 = last_s1 | empty_s1;
	assign adv_s1        = valid_s1 & (~has_result_s1 | ~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
			empty_s1 <= s_axis_tuser;
		end
	end

	// byte decode
	u8c_step u_step (
		.token_mode (token_mode_q),
		.text_byte  (byte_s1),
		.st         (st_q),
		.nxt        (st_nxt)
	);

	assign text_ok_s1 = ~empty_s1 & ~st_nxt.err & (st_nxt.pending == 2'd0);

	// decoder state, cleared at the end of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			if (has_result_s1) st_q <= '0;
			else               st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && has_result_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result_s1) begin
			text_ok_s2 <= text_ok_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, text_ok_s2};

	// checks
	`U8C_ASSERT_NOW(a_idle_ready, !valid_s1, s_axis_tready, "input not ready with stage 1 empty")
	`U8C_ASSERT_NEXT(a_empty_fails, adv_s1 && empty_s1, valid_s2 && !text_ok_s2, "empty string passed")
	`U8C_ASSERT_NEXT(a_end_clears, adv_s1 && has_result_s1, st_q.pending == 2'd0 && !st_q.err, "state kept after string end")
	`U8C_ASSERT_NOW(a_cls_pending, st_q.cls != u8c_pkg::CLS_NORM, st_q.pending != 2'd0, "continuation class set with nothing pending")

endmodule
